/* rtl/core/gradient_fill_pixel_assert.svh */
// assertion macros shared by the gradient fill checkers
`ifndef GRADIENT_FILL_PIXEL_ASSERT_SVH
`define GRADIENT_FILL_PIXEL_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gradient fill check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define GFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gradient fill check failed");

`endif

/* rtl/core/gfp_pkg.sv */
package gfp_pkg;

	// field and datapath widths
	localparam int COORD_W = 12;
	localparam int SIDE_W  = 13;
	localparam int NUM_W   = 13;
	localparam int DEN_W   = 14;
	localparam int CH_W    = 8;
	localparam int PROD_W  = 21;
	localparam int QUO_W   = 8;
	localparam int NUM_CH  = 3;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [1:0] {
		MODE_VERT  = 2'd0,
		MODE_HORIZ = 2'd1,
		MODE_DIAG  = 2'd2,
		MODE_FLAT  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_START  = 3'd0,
		REG_END    = 3'd1,
		REG_MODE   = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]       start_color;
		logic [31:0]       end_color;
		mode_t             gradient_mode;
		logic [SIDE_W-1:0] fill_width;
		logic [SIDE_W-1:0] fill_height;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] col_offset;
		logic [COORD_W-1:0] row_offset;
	} pixel_in_t;

	typedef struct packed {
		logic [31:0] pixel_value;
	} pixel_out_t;

	// per-channel operands after setup
	typedef struct packed {
		logic [CH_W-1:0] start;
		logic [CH_W-1:0] mag;
		logic            neg;
	} setup_lane_t;

	typedef struct packed {
		logic [NUM_W-1:0]          num;
		logic [DEN_W-1:0]          den;
		setup_lane_t [NUM_CH-1:0]  lane;
	} setup_item_t;

	// per-channel division state
	typedef struct packed {
		logic [CH_W-1:0]   start;
		logic              neg;
		logic              sat;
		logic [PROD_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} div_lane_t;

	typedef struct packed {
		logic [DEN_W-1:0]        den;
		div_lane_t [NUM_CH-1:0]  lane;
	} div_item_t;

endpackage

/* rtl/core/gfp_stream_if.sv */
interface gfp_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/gfp_regs.sv */
module gfp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gfp_pkg::ADDR_W-1:0]    paddr,
	input  logic [gfp_pkg::DATA_W-1:0]    pwdata,
	output logic [gfp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output gfp_pkg::cfg_t                 cfg
);
	gfp_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes, access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_color   <= '0;
			cfg_q.end_color     <= '0;
			cfg_q.gradient_mode <= gfp_pkg::MODE_FLAT;
			cfg_q.fill_width    <= gfp_pkg::SIDE_W'(1);
			cfg_q.fill_height   <= gfp_pkg::SIDE_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				gfp_pkg::REG_START:  cfg_q.start_color   <= pwdata;
				gfp_pkg::REG_END:    cfg_q.end_color     <= pwdata;
				gfp_pkg::REG_MODE:   cfg_q.gradient_mode <= gfp_pkg::mode_t'(pwdata[1:0]);
				gfp_pkg::REG_WIDTH:  cfg_q.fill_width    <= pwdata[gfp_pkg::SIDE_W-1:0];
				gfp_pkg::REG_HEIGHT: cfg_q.fill_height   <= pwdata[gfp_pkg::SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			gfp_pkg::REG_START:  prdata = cfg_q.start_color;
			gfp_pkg::REG_END:    prdata = cfg_q.end_color;
			gfp_pkg::REG_MODE:   prdata = {30'd0, cfg_q.gradient_mode};
			gfp_pkg::REG_WIDTH:  prdata = {19'd0, cfg_q.fill_width};
			gfp_pkg::REG_HEIGHT: prdata = {19'd0, cfg_q.fill_height};
			default:             prdata = '0;
		endcase
	end
endmodule

/* rtl/core/gfp_front.sv */
module gfp_front #(
	parameter int MAX_SIDE = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gfp_pkg::cfg_t cfg,
	gfp_stream_if.sink    up,
	gfp_stream_if.source  dn
);
	localparam logic [31:0] SIDE_CAP = 32'(MAX_SIDE);

	logic [gfp_pkg::SIDE_W-1:0] w_lim;
	logic [gfp_pkg::SIDE_W-1:0] h_lim;
	logic [gfp_pkg::NUM_W-1:0]  num_sel;
	logic [gfp_pkg::DEN_W-1:0]  den_sel;
	gfp_pkg::setup_item_t       setup_nxt;
	gfp_pkg::div_item_t         prod_nxt;
	gfp_pkg::div_item_t         sat_nxt;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;
	gfp_pkg::setup_item_t item_s1;
	gfp_pkg::div_item_t   item_s2;
	gfp_pkg::div_item_t   item_s3;

	// ready chain, an empty stage always takes a beat
	assign rdy_s3   = !valid_s3 || dn.ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign up.ready = rdy_s1;
	assign dn.valid = valid_s3;
	assign dn.data  = item_s3;

	// side clamp
	assign w_lim = ({19'd0, cfg.fill_width} > SIDE_CAP) ?
		gfp_pkg::SIDE_W'(MAX_SIDE) : cfg.fill_width;
	assign h_lim = ({19'd0, cfg.fill_height} > SIDE_CAP) ?
		gfp_pkg::SIDE_W'(MAX_SIDE) : cfg.fill_height;

	// factor and span by mode, zero span gives the start colour
	always_comb begin
		case (cfg.gradient_mode)
			gfp_pkg::MODE_VERT: begin
				num_sel = gfp_pkg::NUM_W'(up.data.row_offset);
				den_sel = gfp_pkg::DEN_W'(h_lim);
			end
			gfp_pkg::MODE_HORIZ: begin
				num_sel = gfp_pkg::NUM_W'(up.data.col_offset);
				den_sel = gfp_pkg::DEN_W'(w_lim);
			end
			gfp_pkg::MODE_DIAG: begin
				num_sel = gfp_pkg::NUM_W'(up.data.col_offset) +
					gfp_pkg::NUM_W'(up.data.row_offset);
				den_sel = gfp_pkg::DEN_W'(w_lim) + gfp_pkg::DEN_W'(h_lim);
			end
			default: begin
				num_sel = '0;
				den_sel = gfp_pkg::DEN_W'(1);
			end
		endcase
		setup_nxt.num = (den_sel == '0) ? '0 : num_sel;
		setup_nxt.den = (den_sel == '0) ? gfp_pkg::DEN_W'(1) : den_sel;
		for (int ch = 0; ch < gfp_pkg::NUM_CH; ch++) begin
			setup_nxt.lane[ch].start = cfg.start_color[ch*8 +: 8];
			setup_nxt.lane[ch].neg   = cfg.end_color[ch*8 +: 8] < cfg.start_color[ch*8 +: 8];
			setup_nxt.lane[ch].mag   = setup_nxt.lane[ch].neg ?
				cfg.start_color[ch*8 +: 8] - cfg.end_color[ch*8 +: 8] :
				cfg.end_color[ch*8 +: 8] - cfg.start_color[ch*8 +: 8];
		end
	end

	// factor times colour delta magnitude
	always_comb begin
		prod_nxt.den = item_s1.den;
		for (int ch = 0; ch < gfp_pkg::NUM_CH; ch++) begin
			prod_nxt.lane[ch].start = item_s1.lane[ch].start;
			prod_nxt.lane[ch].neg   = item_s1.lane[ch].neg;
			prod_nxt.lane[ch].sat   = 1'b0;
			prod_nxt.lane[ch].quo   = '0;
			prod_nxt.lane[ch].rem   = gfp_pkg::PROD_W'(item_s1.num) *
				gfp_pkg::PROD_W'(item_s1.lane[ch].mag);
		end
	end

	// quotient of 256 or more saturates the channel either way
	always_comb begin
		sat_nxt = item_s2;
		for (int ch = 0; ch < gfp_pkg::NUM_CH; ch++) begin
			sat_nxt.lane[ch].sat = {1'b0, item_s2.lane[ch].rem} >= {item_s2.den, 8'd0};
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= up.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (rdy_s1) item_s1 <= setup_nxt;
		if (rdy_s2) item_s2 <= prod_nxt;
		if (rdy_s3) item_s3 <= sat_nxt;
	end
endmodule

/* rtl/core/gfp_divider.sv */
module gfp_divider (
	input  logic         clk,
	input  logic         arst_n,
	gfp_stream_if.sink   up,
	gfp_stream_if.source dn
);
	localparam int STEPS = gfp_pkg::QUO_W;

	logic [STEPS-1:0]   valid_s;
	logic [STEPS:0]     rdy;
	gfp_pkg::div_item_t item_s   [STEPS];
	gfp_pkg::div_item_t prev     [STEPS];
	gfp_pkg::div_item_t step_nxt [STEPS];
	logic [STEPS-1:0]   prev_valid;

	assign rdy[STEPS] = dn.ready;
	assign up.ready   = rdy[0];
	assign dn.valid   = valid_s[STEPS-1];
	assign dn.data    = item_s[STEPS-1];

	// one restoring step per stage, quotient msb first
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int BIT = STEPS - 1 - i;

		if (i == 0) begin : g_head
			assign prev[i]       = up.data;
			assign prev_valid[i] = up.valid;
		end else begin : g_body
			assign prev[i]       = item_s[i-1];
			assign prev_valid[i] = valid_s[i-1];
		end

		assign rdy[i] = !valid_s[i] || rdy[i+1];

		always_comb begin
			logic [gfp_pkg::PROD_W:0] dshift;
			logic [gfp_pkg::PROD_W:0] diff;
			step_nxt[i] = prev[i];
			dshift = (gfp_pkg::PROD_W+1)'(prev[i].den) << BIT;
			for (int ch = 0; ch < gfp_pkg::NUM_CH; ch++) begin
				diff = {1'b0, prev[i].lane[ch].rem} - dshift;
				if (!diff[gfp_pkg::PROD_W]) begin
					step_nxt[i].lane[ch].rem      = diff[gfp_pkg::PROD_W-1:0];
					step_nxt[i].lane[ch].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				valid_s[i] <= prev_valid[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) item_s[i] <= step_nxt[i];
		end
	end
endmodule

/* rtl/core/gfp_back.sv */
module gfp_back (
	input  logic         clk,
	input  logic         arst_n,
	gfp_stream_if.sink   up,
	gfp_stream_if.source dn
);
	logic                valid_s12;
	gfp_pkg::pixel_out_t pixel_s12;
	gfp_pkg::pixel_out_t pixel_nxt;
	logic                rdy_s12;

	assign rdy_s12  = !valid_s12 || dn.ready;
	assign up.ready = rdy_s12;
	assign dn.valid = valid_s12;
	assign dn.data  = pixel_s12;

	// signed offset onto start value, then clamp to 0..255
	always_comb begin
		logic [8:0]        q;
		logic signed [9:0] v;
		pixel_nxt.pixel_value[31:24] = gfp_pkg::ALPHA_OPAQUE;
		for (int ch = 0; ch < gfp_pkg::NUM_CH; ch++) begin
			q = up.data.lane[ch].sat ? 9'd256 : {1'b0, up.data.lane[ch].quo};
			v = up.data.lane[ch].neg ?
				$signed({2'b00, up.data.lane[ch].start}) - $signed({1'b0, q}) :
				$signed({2'b00, up.data.lane[ch].start}) + $signed({1'b0, q});
			if (v[9])
				pixel_nxt.pixel_value[ch*8 +: 8] = 8'd0;
			else if (v[8])
				pixel_nxt.pixel_value[ch*8 +: 8] = 8'hFF;
			else
				pixel_nxt.pixel_value[ch*8 +: 8] = v[7:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else if (rdy_s12) begin
			valid_s12 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s12) pixel_s12 <= pixel_nxt;
	end
endmodule

/* rtl/core/gradient_fill_pixel.sv */
// Linear colour gradient fill, one ARGB8888 pixel per beat.
// pix_in carries a pixel's column and row offset inside the clipped fill
// rectangle; pix_out returns its colour with alpha forced to 0xFF.
// Colours, mode and rectangle size are to be set over the APB port (start colour,
// end colour, mode, width, height at byte addresses 0, 4, 8, 12, 16) only while
// no pixel is in flight, which the block does not enforce; pready is always high.
// Each input beat passes setup, multiply,
// saturation check, eight restoring divide stages (one quotient bit each)
// and the output register. Throughput is one pixel per clock while pix_out.ready
// stays high; every stage holds at most one beat and the divider chain sets the depth.
// Reset clears all stage valid bits and loads start and end colour 0,
// flat mode and a 1x1 rectangle.
// When the receiver stalls the result holds in the output register while
// earlier stages keep filling their empty slots; pix_in.ready falls only
// once every stage holds a beat, and nothing is dropped or repeated.
module gradient_fill_pixel #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gfp_pkg::ADDR_W-1:0] paddr,
	input  logic [gfp_pkg::DATA_W-1:0] pwdata,
	output logic [gfp_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	gfp_stream_if.sink                 pix_in,
	gfp_stream_if.source               pix_out
);
	gfp_pkg::cfg_t cfg;

	gfp_stream_if #(.data_t(gfp_pkg::div_item_t)) front_to_div ();
	gfp_stream_if #(.data_t(gfp_pkg::div_item_t)) div_to_back ();

	// configuration registers
	gfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// operand setup, product, saturation check
	gfp_front #(.MAX_SIDE(MAX_SIDE)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.up     (pix_in),
		.dn     (front_to_div)
	);

	// pipelined quotient
	gfp_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (front_to_div),
		.dn     (div_to_back)
	);

	// channel assembly and output register
	gfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (div_to_back),
		.dn     (pix_out)
	);
endmodule

/* rtl/core/gfp_checker.sv */
`include "gradient_fill_pixel_assert.svh"

module gfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_pixel
);
	// a stalled result beat holds its value
	`GFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel))

	// a ready receiver never backs up the input side
	`GFP_ASSERT_NOW(a_ready_pass, out_ready, in_ready)

	// with no result waiting the pipeline has room
	`GFP_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)

	// no result right after reset is released
	`GFP_ASSERT_NOW(a_reset_empty, $rose(arst_n), !out_valid)
endmodule

bind gradient_fill_pixel gfp_checker u_gfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_pixel (pix_out.data.pixel_value)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int SIDE_MAX    = 4096;
	localparam int CH_MAX      = 255;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_PIX   = 300;
	localparam int CFG_EVERY   = 60;
	localparam int DIR_ROWS    = 20;

	localparam gfp_pkg::cfg_t CFG_RESET = '{32'h0, 32'h0, gfp_pkg::MODE_FLAT, 13'd1, 13'd1};

	// one directed pixel, with an optional register setting before it
	typedef struct {
		bit            set_cfg;
		gfp_pkg::cfg_t cfg;
		logic [11:0]   col;
		logic [11:0]   row;
		bit            has_exp;
		logic [31:0]   exp_px;
	} dir_row_t;

	// hand-typed pixel value travelling with a beat
	typedef struct {
		bit          has;
		logic [31:0] val;
	} typed_px_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [gfp_pkg::ADDR_W-1:0] paddr;
	logic [gfp_pkg::DATA_W-1:0] pwdata;
	logic [gfp_pkg::DATA_W-1:0] prdata;
	logic pready;

	gfp_stream_if #(.data_t(gfp_pkg::pixel_in_t))  pix_in ();
	gfp_stream_if #(.data_t(gfp_pkg::pixel_out_t)) pix_out ();

	gradient_fill_pixel DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	always #2 clk = ~clk;

	gfp_pkg::cfg_t cur_cfg = CFG_RESET;
	logic [31:0]   pixel_expect_q[$];
	typed_px_t     typed_q[$];
	typed_px_t     typed_head;
	int            idle_pct = 0;
	int            stall_pct = 0;
	bit            hold_req = 1'b0;
	bit            hold_done = 1'b0;
	int            hold_left = 0;
	int            quiet_cycles = 0;
	int            mismatches = 0;
	int            pixels_in = 0;
	int            pixels_out = 0;
	int            cfg_count = 0;

	dir_row_t dir_tab [DIR_ROWS] = '{
		// reset values: flat black
		'{1'b0, CFG_RESET, 12'h000, 12'h000, 1'b1, 32'hFF000000},
		'{1'b0, CFG_RESET, 12'hFFF, 12'hFFF, 1'b1, 32'hFF000000},
		// flat mode ignores offsets and start alpha
		'{1'b1, '{32'h12345678, 32'h00ABCDEF, gfp_pkg::MODE_FLAT, 13'd1, 13'd1},
			12'h005, 12'h007, 1'b1, 32'hFF345678},
		// vertical ramp, origin, far edge, outside the rectangle
		'{1'b1, '{32'h00000000, 32'h00FFFFFF, gfp_pkg::MODE_VERT, 13'd256, 13'd256},
			12'h000, 12'h000, 1'b1, 32'hFF000000},
		'{1'b0, CFG_RESET, 12'hFFF, 12'h0FF, 1'b0, 32'h0},
		'{1'b0, CFG_RESET, 12'h000, 12'hFFF, 1'b1, 32'hFFFFFFFF},
		// falling and rising channels both saturate
		'{1'b1, '{32'h00FF00FF, 32'h0000FF00, gfp_pkg::MODE_VERT, 13'd256, 13'd256},
			12'h000, 12'hFFF, 1'b1, 32'hFF00FF00},
		// horizontal at the largest side, then an oversized one
		'{1'b1, '{32'h00000000, 32'h00FFFFFF, gfp_pkg::MODE_HORIZ, 13'd4096, 13'd1},
			12'hFFF, 12'h000, 1'b0, 32'h0},
		'{1'b0, CFG_RESET, 12'h800, 12'h000, 1'b0, 32'h0},
		'{1'b1, '{32'h00000000, 32'h00FFFFFF, gfp_pkg::MODE_HORIZ, 13'd8191, 13'd1},
			12'h800, 12'h000, 1'b0, 32'h0},
		// zero spans fall back to the start colour
		'{1'b1, '{32'h00102030, 32'h00FFFFFF, gfp_pkg::MODE_HORIZ, 13'd0, 13'd1},
			12'h064, 12'h000, 1'b1, 32'hFF102030},
		'{1'b1, '{32'h00102030, 32'h00000000, gfp_pkg::MODE_VERT, 13'd1, 13'd0},
			12'h000, 12'h037, 1'b1, 32'hFF102030},
		'{1'b1, '{32'h00102030, 32'h00FFFFFF, gfp_pkg::MODE_DIAG, 13'd0, 13'd0},
			12'hFFF, 12'hFFF, 1'b1, 32'hFF102030},
		// diagonal at full and oversized sides
		'{1'b1, '{32'h00000000, 32'h00FFFFFF, gfp_pkg::MODE_DIAG, 13'd4096, 13'd4096},
			12'hFFF, 12'hFFF, 1'b0, 32'h0},
		'{1'b1, '{32'h00000000, 32'h00FFFFFF, gfp_pkg::MODE_DIAG, 13'd8191, 13'd8191},
			12'hFFF, 12'hFFF, 1'b0, 32'h0},
		'{1'b1, '{32'h00FFFFFF, 32'h00000000, gfp_pkg::MODE_DIAG, 13'd1, 13'd1},
			12'hFFF, 12'hFFF, 1'b1, 32'hFF000000},
		'{1'b1, '{32'h00804020, 32'h00FFFFFF, gfp_pkg::MODE_FLAT, 13'd0, 13'd0},
			12'h003, 12'h009, 1'b1, 32'hFF804020},
		'{1'b1, '{32'hFFAABBCC, 32'h00112233, gfp_pkg::MODE_HORIZ, 13'd1, 13'd1},
			12'h000, 12'h000, 1'b1, 32'hFFAABBCC},
		'{1'b1, '{32'h00000000, 32'h00FF0000, gfp_pkg::MODE_VERT, 13'd4096, 13'd4096},
			12'h000, 12'hFFF, 1'b0, 32'h0},
		'{1'b1, '{32'h00FF8000, 32'h00000000, gfp_pkg::MODE_HORIZ, 13'd3, 13'd3},
			12'h002, 12'h001, 1'b0, 32'h0}
	};

	// expected colour of one pixel under a register setting
	function automatic logic [31:0] predict_pixel(gfp_pkg::cfg_t c, gfp_pkg::pixel_in_t px);
		int w, h, num, den, s, e, v;
		logic [31:0] pix;
		w = (c.fill_width > SIDE_MAX) ? SIDE_MAX : int'(c.fill_width);
		h = (c.fill_height > SIDE_MAX) ? SIDE_MAX : int'(c.fill_height);
		case (c.gradient_mode)
			gfp_pkg::MODE_VERT: begin
				num = int'(px.row_offset);
				den = h;
			end
			gfp_pkg::MODE_HORIZ: begin
				num = int'(px.col_offset);
				den = w;
			end
			gfp_pkg::MODE_DIAG: begin
				num = int'(px.col_offset) + int'(px.row_offset);
				den = w + h;
			end
			default: begin
				num = 0;
				den = 1;
			end
		endcase
		pix = {gfp_pkg::ALPHA_OPAQUE, 24'h0};
		for (int k = 0; k < gfp_pkg::NUM_CH; k++) begin
			s = int'(c.start_color[gfp_pkg::CH_W*k +: gfp_pkg::CH_W]);
			e = int'(c.end_color[gfp_pkg::CH_W*k +: gfp_pkg::CH_W]);
			v = s;
			if (den > 0)
				v = s + (num * (e - s)) / den;
			if (v < 0)
				v = 0;
			if (v > CH_MAX)
				v = CH_MAX;
			pix[gfp_pkg::CH_W*k +: gfp_pkg::CH_W] = v[gfp_pkg::CH_W-1:0];
		end
		return pix;
	endfunction

	// side length biased to small values with zero and oversized cases
	function automatic logic [gfp_pkg::SIDE_W-1:0] rand_side();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return gfp_pkg::SIDE_W'(SIDE_MAX);
		if (r < 22)
			return gfp_pkg::SIDE_W'($urandom_range(8191, SIDE_MAX + 1));
		if (r < 30)
			return gfp_pkg::SIDE_W'($urandom_range(SIDE_MAX - 1, 1024));
		return gfp_pkg::SIDE_W'($urandom_range(64, 1));
	endfunction

	function automatic logic [31:0] rand_color();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic gfp_pkg::cfg_t rand_cfg();
		gfp_pkg::cfg_t c;
		c.start_color   = rand_color();
		c.end_color     = rand_color();
		c.gradient_mode = gfp_pkg::mode_t'($urandom_range(3));
		c.fill_width    = rand_side();
		c.fill_height   = rand_side();
		return c;
	endfunction

	// offset mostly inside the rectangle, sometimes anywhere
	function automatic logic [gfp_pkg::COORD_W-1:0] rand_offset(
			logic [gfp_pkg::SIDE_W-1:0] side);
		int lim;
		lim = (side > SIDE_MAX) ? SIDE_MAX : int'(side);
		if (lim == 0 || $urandom_range(99) < 15)
			return gfp_pkg::COORD_W'($urandom_range(SIDE_MAX - 1));
		return gfp_pkg::COORD_W'($urandom_range(lim - 1));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch %s: got %08h expected %08h", $time, what, got, want);
		mismatches++;
	endtask

	// setup and access beats; psel stays high for a following write
	task automatic write_reg(gfp_pkg::reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			gfp_pkg::REG_START:  cur_cfg.start_color = val;
			gfp_pkg::REG_END:    cur_cfg.end_color = val;
			gfp_pkg::REG_MODE:   cur_cfg.gradient_mode = gfp_pkg::mode_t'(val[1:0]);
			gfp_pkg::REG_WIDTH:  cur_cfg.fill_width = val[gfp_pkg::SIDE_W-1:0];
			gfp_pkg::REG_HEIGHT: cur_cfg.fill_height = val[gfp_pkg::SIDE_W-1:0];
			default: ;
		endcase
	endtask

	// read one register back and compare
	task automatic read_check(gfp_pkg::reg_idx_t idx, logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata != want)
			report_mismatch("register readback", prdata, want);
	endtask

	// upper bits of the narrow registers carry noise that must be ignored
	task automatic program_cfg(gfp_pkg::cfg_t c, bit noisy);
		logic [31:0] junk;
		junk = noisy ? $urandom : '0;
		write_reg(gfp_pkg::REG_START, c.start_color);
		write_reg(gfp_pkg::REG_END, c.end_color);
		write_reg(gfp_pkg::REG_MODE, {junk[31:2], c.gradient_mode});
		write_reg(gfp_pkg::REG_WIDTH, {junk[31:gfp_pkg::SIDE_W], c.fill_width});
		write_reg(gfp_pkg::REG_HEIGHT, {junk[31:gfp_pkg::SIDE_W], c.fill_height});
		read_check(gfp_pkg::REG_WIDTH, {19'd0, c.fill_width});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_count++;
	endtask

	// offer one pixel beat and wait until it is taken
	task automatic send_pixel(gfp_pkg::pixel_in_t px, bit has_exp, logic [31:0] exp_px);
		typed_q.push_back('{has_exp, exp_px});
		while ($urandom_range(99) < idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.data  <= px;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
	endtask

	task automatic drain_pipe();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pixel_expect_q.size() != 0 || typed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// input beats: predict at acceptance
	always @(posedge clk) begin
		if (arst_n && pix_in.valid && pix_in.ready) begin
			typed_head = typed_q.pop_front();
			pixel_expect_q.push_back(typed_head.has ? typed_head.val :
				predict_pixel(cur_cfg, pix_in.data));
			pixels_in++;
		end
	end

	// output beats: compare against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pixel_expect_q.size() == 0)
				report_mismatch("unexpected beat", pix_out.data.pixel_value, 32'h0);
			else if (pix_out.data.pixel_value != pixel_expect_q[0])
				report_mismatch("pixel_value", pix_out.data.pixel_value,
					pixel_expect_q[0]);
			if (pixel_expect_q.size() != 0)
				void'(pixel_expect_q.pop_front());
			pixels_out++;
		end
	end

	// watchdog on cycles without any beat or register access
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
					|| (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("FAIL gradient_fill_pixel");
				$finish;
			end
		end
	end

	// receiver: random stalls plus one long hold when requested
	initial begin
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	int idle_tab [4]  = '{0, 83, 0, 8};
	int stall_tab [4] = '{0, 0, 83, 8};

	initial begin
		gfp_pkg::pixel_in_t px;
		gfp_pkg::cfg_t      rc;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pix_in.valid = 1'b0;
		pix_in.data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_cfg) begin
				drain_pipe();
				program_cfg(dir_tab[i].cfg, 1'b0);
			end
			px.col_offset = dir_tab[i].col;
			px.row_offset = dir_tab[i].row;
			send_pixel(px, dir_tab[i].has_exp, dir_tab[i].exp_px);
		end

		// random phases with different idling and stalling
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_tab[ph];
			stall_pct = stall_tab[ph];
			for (int n = 0; n < PHASE_PIX; n++) begin
				if (n % CFG_EVERY == 0) begin
					drain_pipe();
					rc = rand_cfg();
					program_cfg(rc, 1'b1);
				end
				if (ph == 0 && n == 100)
					hold_req = 1'b1;
				px.col_offset = rand_offset(cur_cfg.fill_width);
				px.row_offset = rand_offset(cur_cfg.fill_height);
				send_pixel(px, 1'b0, 32'h0);
			end
		end

		drain_pipe();
		$display("covered %0d pixels in, %0d out, under %0d register settings: all modes,",
			pixels_in, pixels_out, cfg_count);
		$display("zero, full and oversized spans, offsets outside the fill, long output hold");
		if (mismatches == 0)
			$display("PASS gradient_fill_pixel");
		else
			$display("FAIL gradient_fill_pixel");
		$finish;
	end

endmodule
